### hdl/wbod_pkg.sv
// Package for the weighted bond-order density block: sizes, payload structs,
// register indexes, state encoding and the exp2 fraction table.
// No dependencies.
`default_nettype none
package wbod_pkg;

   localparam int MAX_NEIGHBOURS  = 32;
   localparam int EXP_TABLE_DEPTH = 256;
   localparam int ROOT_BITS       = 24;
   localparam logic [16:0] INV_LN2_Q16 = 17'd94548;

   localparam int ADDR_W  = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;
   localparam int CNT_W   = $clog2(MAX_NEIGHBOURS + 1);
   localparam int TOT_W   = $clog2(65535 * MAX_NEIGHBOURS + 1);
   localparam int SUM_W   = 33 + CNT_W;
   localparam int DVD_W   = SUM_W + 8;
   localparam int QUO_W   = 25;
   localparam int QCNT_W  = $clog2(QUO_W + 1);
   localparam int EXP_IW  = $clog2(EXP_TABLE_DEPTH);
   localparam int ENTRY_W = 64;

   typedef enum logic [1:0] {
      KIND_CLEAR = 2'd0,
      KIND_ADD   = 2'd1,
      KIND_QUERY = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      CSR_KERNEL_MODE = 2'd0,
      CSR_CONE_COSINE = 2'd1,
      CSR_KAPPA       = 2'd2,
      CSR_SCALE       = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DIV,
      ST_MUL,
      ST_SAT
   } state_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [15:0] vec_x;
      logic signed [15:0] vec_y;
      logic signed [15:0] vec_z;
      logic [15:0]        bond_weight;
   } req_type;

   typedef struct packed {
      logic [31:0] density;
      logic        no_neighbours;
      logic        saturated;
   } rsp_type;

   typedef logic [16:0] exp_rom_type [EXP_TABLE_DEPTH];

   function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
      logic [63:0] x;
      logic [63:0] res;
      logic [63:0] bitv;
      x    = x_in;
      res  = '0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x   = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // 2^(-i/DEPTH) in Q1.16 by products of repeated square roots of one half
   function automatic exp_rom_type build_exp_rom();
      exp_rom_type rom;
      logic [63:0] root [ROOT_BITS + 1];
      logic [63:0] q;
      logic [63:0] p;
      root[0] = 64'd1 << 29;
      for (int b = 1; b <= ROOT_BITS; b++) root[b] = isqrt64(root[b - 1] << 30);
      for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
         q = (64'(i) << ROOT_BITS) / EXP_TABLE_DEPTH;
         p = 64'd1 << 30;
         for (int b = 1; b <= ROOT_BITS; b++)
            if (q[ROOT_BITS - b]) p = (p * root[b]) >> 30;
         rom[i] = 17'((p + (64'd1 << 13)) >> 14);
      end
      return rom;
   endfunction

   localparam exp_rom_type EXP_ROM = build_exp_rom();

endpackage
`default_nettype wire

### hdl/wbod_bond_ram.sv
// Bond store: one entry per neighbour, {x, y, z, weight}, one write and one
// registered read port. Depends on wbod_pkg.
`default_nettype none
module wbod_bond_ram
   import wbod_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [ADDR_W-1:0]  wr_addr,
   input  wire logic [ENTRY_W-1:0] wr_data,
   input  wire logic               rd_en,
   input  wire logic [ADDR_W-1:0]  rd_addr,
   output logic      [ENTRY_W-1:0] rd_data
);

   logic [ENTRY_W-1:0] mem [MAX_NEIGHBOURS];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

### hdl/wbod_div.sv
// Restoring divider, one quotient bit per cycle, for the weight-total
// normalization. Depends on wbod_pkg.
`default_nettype none
module wbod_div
   import wbod_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DVD_W-1:0] dividend,
   input  wire logic [TOT_W-1:0] divisor,
   output logic                  done,
   output logic      [QUO_W-1:0] quotient
);

   logic [TOT_W-1:0]  rem_ff, rem_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic [TOT_W:0]    trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[QUO_W-1]};
      if (start) begin
         // quotient stays below 2^QUO_W, so the high part is below the divisor
         rem_in = TOT_W'(dividend >> QUO_W);
         quo_in = dividend[QUO_W-1:0];
         cnt_in = QCNT_W'(QUO_W);
      end else if (cnt_ff != '0) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = TOT_W'(trial - {1'b0, divisor});
            quo_in = {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_in = TOT_W'(trial);
            quo_in = {quo_ff[QUO_W-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == QCNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   assert property (@(posedge clock) disable iff (reset) done |-> cnt_ff == '0)
      else $error("divider done while still iterating");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == QCNT_W'(1) && !start) |=> done)
      else $error("divider missed its done pulse");
   assert property (@(posedge clock) disable iff (reset) cnt_ff <= QCNT_W'(QUO_W))
      else $error("divider count out of range");

endmodule
`default_nettype wire

### hdl/weighted_bond_order_density.sv
// Weighted bond-order density: kernel density over stored unit bond vectors.
// Clear and add leave busy low. A query with a zero weight total answers on the
// next cycle. Otherwise a query holds busy, and no new query is taken, while it
// scans the N stored bonds (one memory read a cycle), divides by the weight
// total (one quotient bit a cycle), then multiplies and clips; the result is
// registered. The receiver cannot stall. Synchronous reset clears the state,
// count, weight total and configuration registers; the store needs none.
`default_nettype none
module weighted_bond_order_density
   import wbod_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire req_type     req,
   output logic             rsp_strobe,
   output rsp_type          rsp,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   // configuration
   logic               mode_ff;
   logic signed [15:0] cone_ff;
   logic [15:0]        kappa_ff;
   logic [31:0]        scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         cone_ff  <= '0;
         kappa_ff <= 16'd256;
         scale_ff <= 32'd10430;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_KERNEL_MODE: mode_ff  <= csr_wdata[0];
            CSR_CONE_COSINE: cone_ff  <= csr_wdata[15:0];
            CSR_KAPPA:       kappa_ff <= csr_wdata[15:0];
            CSR_SCALE:       scale_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [TOT_W-1:0]  total_ff, total_in;
   logic [CNT_W-1:0]  issue_ff, issue_in;
   logic [7:1]        vld_ff;
   logic              accept, is_add, is_query, can_add, empty_query;
   logic              rd_en, div_start, drained;
   logic [ENTRY_W-1:0] rd_data;
   logic              div_done;
   logic [QUO_W-1:0]  quotient;
   logic [SUM_W-1:0]  acc_ff, acc_in;
   logic signed [15:0] qx_ff, qy_ff, qz_ff;

   assign accept      = start && !busy;
   assign is_add      = accept && (kind_type'(req.kind) == KIND_ADD);
   assign is_query    = accept && (kind_type'(req.kind) == KIND_QUERY);
   assign can_add     = count_ff < CNT_W'(MAX_NEIGHBOURS);
   assign empty_query = is_query && (total_ff == '0);
   assign drained     = (issue_ff == count_ff) && (vld_ff == '0);

   wbod_bond_ram u_ram (
      .clock   (clock),
      .wr_en   (is_add && can_add),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data ({req.vec_x, req.vec_y, req.vec_z, req.bond_weight}),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   wbod_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({acc_ff, 8'd0}),
      .divisor  (total_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (is_query && !empty_query) state_in = ST_SCAN;
         ST_SCAN: if (drained) state_in = ST_DIV;
         ST_DIV:  if (div_done) state_in = ST_MUL;
         ST_MUL:  state_in = ST_SAT;
         ST_SAT:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      busy      = 1'b1;
      rd_en     = 1'b0;
      div_start = 1'b0;
      case (state_ff)
         ST_IDLE: busy = 1'b0;
         ST_SCAN: begin
            rd_en     = (issue_ff != count_ff);
            div_start = drained;
         end
         default: ;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      total_in = total_ff;
      issue_in = issue_ff;
      if (accept && kind_type'(req.kind) == KIND_CLEAR) begin
         count_in = '0;
         total_in = '0;
      end else if (is_add && can_add) begin
         count_in = count_ff + 1'b1;
         total_in = total_ff + TOT_W'(req.bond_weight);
      end
      if (accept) issue_in = '0;
      else if (rd_en) issue_in = issue_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         total_ff <= '0;
         issue_ff <= '0;
         vld_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         total_ff <= total_in;
         issue_ff <= issue_in;
         vld_ff   <= {vld_ff[6:1], rd_en};
      end
   end

   always_ff @(posedge clock) begin
      if (is_query) begin
         qx_ff <= req.vec_x;
         qy_ff <= req.vec_y;
         qz_ff <= req.vec_z;
      end
   end

   // kernel pipeline
   logic signed [31:0] px_ff, py_ff, pz_ff;
   logic [15:0]        wt2_ff, wt3_ff, wt4_ff, wt5_ff, wt6_ff;
   logic signed [33:0] dot;
   logic [32:0]        gap;
   logic               hit3_ff, hit4_ff, hit5_ff;
   logic [17:0]        g15_ff;
   logic [33:0]        t_ff;
   logic [50:0]        w_ff;
   logic [16:0]        k_ff, k_in;
   logic [32:0]        kw_ff;

   assign dot = 34'(px_ff) + 34'(py_ff) + 34'(pz_ff);
   assign gap = (dot >= 34'sd1073741824) ? '0 : 33'(34'sd1073741824 - dot);

   always_comb begin
      if (!mode_ff) k_in = hit5_ff ? 17'd65536 : '0;
      else if (w_ff[50:44] != '0) k_in = '0;
      else k_in = EXP_ROM[w_ff[38 -: EXP_IW]] >> w_ff[43:39];
   end

   always_ff @(posedge clock) begin
      px_ff   <= $signed(rd_data[63:48]) * qx_ff;
      py_ff   <= $signed(rd_data[47:32]) * qy_ff;
      pz_ff   <= $signed(rd_data[31:16]) * qz_ff;
      wt2_ff  <= rd_data[15:0];
      hit3_ff <= dot > (34'(cone_ff) <<< 15);
      g15_ff  <= gap[32:15];
      wt3_ff  <= wt2_ff;
      t_ff    <= kappa_ff * g15_ff;
      hit4_ff <= hit3_ff;
      wt4_ff  <= wt3_ff;
      w_ff    <= t_ff * INV_LN2_Q16;
      hit5_ff <= hit4_ff;
      wt5_ff  <= wt4_ff;
      k_ff    <= k_in;
      wt6_ff  <= wt5_ff;
      kw_ff   <= k_ff * wt6_ff;
   end

   always_comb begin
      acc_in = acc_ff;
      if (is_query) acc_in = '0;
      else if (vld_ff[7]) acc_in = acc_ff + SUM_W'(kw_ff);
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // scale, clip, respond
   logic [56:0] prod_ff;
   logic [32:0] dens;
   rsp_type     rsp_ff, rsp_in;
   logic        strobe_ff, strobe_in;

   assign dens = prod_ff[56:24];

   always_ff @(posedge clock) begin
      if (div_done) prod_ff <= scale_ff * quotient;
   end

   always_comb begin
      rsp_in    = rsp_ff;
      strobe_in = 1'b0;
      if (empty_query) begin
         rsp_in    = '{density: '0, no_neighbours: 1'b1, saturated: 1'b0};
         strobe_in = 1'b1;
      end else if (state_ff == ST_SAT) begin
         rsp_in.no_neighbours = 1'b0;
         rsp_in.saturated     = dens[32];
         rsp_in.density       = dens[32] ? 32'hFFFF_FFFF : dens[31:0];
         strobe_in            = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) strobe_ff <= 1'b0;
      else strobe_ff <= strobe_in;
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp        = rsp_ff;

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> vld_ff == '0)
      else $error("scan pipeline busy while idle");
   assert property (@(posedge clock) disable iff (reset) issue_ff <= count_ff)
      else $error("read pointer beyond stored bonds");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && div_done) |=> state_ff == ST_MUL)
      else $error("divider result not taken");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp.no_neighbours) |-> (!rsp.saturated && rsp.density == '0))
      else $error("empty query carries a density");

endmodule
`default_nettype wire
